/* design/mbrtu_pkg.sv */
package mbrtu_pkg;

  // Defaults for the top-level parameters
  localparam int MBRTU_NUM_REGS  = 16;
  localparam int MBRTU_MAX_FRAME = 256;

  // CRC-16, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Protocol codes
  localparam logic [7:0] FC_READ_INPUT    = 8'h04;
  localparam logic [7:0] EXC_FLAG         = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;

  // Request kinds on in_tuser
  localparam logic REQ_BUS_BYTE = 1'b0;
  localparam logic REQ_REG_UPD  = 1'b1;

  // Response header byte positions
  localparam logic [1:0] HEAD_ADDR = 2'd0;
  localparam logic [1:0] HEAD_FUNC = 2'd1;
  localparam logic [1:0] HEAD_INFO = 2'd2;

  // Minimum frame length that is evaluated
  localparam int MIN_FRAME = 8;
  localparam int HDR_LEN   = 6;

  typedef enum logic [2:0] {
    S_RX,
    S_CHECK,
    S_HEAD,
    S_RD,
    S_HI,
    S_LO,
    S_CRC_LO,
    S_CRC_HI
  } state_t;

  typedef enum logic [2:0] {
    SRC_HEAD,
    SRC_HI,
    SRC_LO,
    SRC_CRC_LO,
    SRC_CRC_HI
  } src_t;

  // Controller to datapath
  typedef struct packed {
    logic rx_take;
    logic upd_take;
    logic clear_frame;
    logic start_resp;
    logic emit;
    src_t src;
    logic rd_issue;
    logic reg_next;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_ok;
    logic resp_exc;
    logic head_last;
    logic regs_last;
    logic out_free;
  } sts_t;

  // One byte through the CRC-16 shift register
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* design/modbus_rtu_slave_read_input_regs.sv */
// Modbus RTU slave, function 04 (read input registers).
// Input channel in_*: one request per beat. in_tuser selects the kind:
// 0 = received bus byte (in_tdata[7:0], in_tlast marks the frame end),
// 1 = register bank write (in_tdata[11:8] index, in_tdata[27:12] value).
// Output channel out_*: one response byte per beat, out_tlast on the CRC
// high byte. Config channel cfg_*: slave address, always ready.
// Requests are taken one per cycle while the block receives. A frame end
// is evaluated in S_CHECK; a dropped frame reopens input after it. Else the
// response is three header bytes at one per cycle while output is free,
// then per register a bank RAM read, high byte and low byte (not for an
// exception), then two CRC bytes. Input is held off (in_tready low) until
// the last response byte is loaded into the output register.
// Reset clears the frame state, the output register and the bank valid
// bits, so all registers read as zero until written; the slave address
// returns to 1. A stalled receiver holds the output register and the
// response sequencer waits on it without losing or repeating bytes.
module modbus_rtu_slave_read_input_regs
  import mbrtu_pkg::*;
  #(parameter int NUM_REGS  = MBRTU_NUM_REGS,
    parameter int MAX_FRAME = MBRTU_MAX_FRAME)
  (input  logic        clk,
   input  logic        rst_n,
   input  logic        in_tvalid,
   output logic        in_tready,
   input  logic [31:0] in_tdata,   // rx_byte[7:0], reg_index[11:8], reg_value[27:12], zero
   input  logic        in_tlast,
   input  logic        in_tuser,   // req_type
   output logic        out_tvalid,
   input  logic        out_tready,
   output logic [7:0]  out_tdata,  // tx_byte[7:0]
   output logic        out_tlast,
   input  logic        cfg_valid,
   output logic        cfg_ready,
   input  logic [7:0]  cfg_data);

  cmd_t cmd;
  sts_t sts;

  mbrtu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbrtu_dp #(.NUM_REGS(NUM_REGS), .MAX_FRAME(MAX_FRAME)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* design/mbrtu_ram.sv */
module mbrtu_ram
  #(parameter int WIDTH = 16,
    parameter int DEPTH = 16)
  (input  logic                                  clk,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata_r);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

/* design/mbrtu_ctrl.sv */
module mbrtu_ctrl
  import mbrtu_pkg::*;
  (input  logic clk,
   input  logic rst_n,
   input  logic in_tvalid,
   input  logic in_tuser,
   input  logic in_tlast,
   output logic in_tready,
   input  sts_t sts,
   output cmd_t cmd);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt       = state_r;
    in_tready       = 1'b0;
    cmd             = '0;
    cmd.src         = SRC_HEAD;
    case (state_r)
      S_RX: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == REQ_REG_UPD) begin
            cmd.upd_take = 1'b1;
          end else begin
            cmd.rx_take = 1'b1;
            if (in_tlast) state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.frame_ok) begin
          cmd.start_resp = 1'b1;
          state_nxt      = S_HEAD;
        end else begin
          cmd.clear_frame = 1'b1;
          state_nxt       = S_RX;
        end
      end
      S_HEAD: begin
        cmd.src = SRC_HEAD;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.head_last) state_nxt = sts.resp_exc ? S_CRC_LO : S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_HI;
      end
      S_HI: begin
        cmd.src = SRC_HI;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_LO;
        end
      end
      S_LO: begin
        cmd.src = SRC_LO;
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.reg_next = 1'b1;
          state_nxt    = sts.regs_last ? S_CRC_LO : S_RD;
        end
      end
      S_CRC_LO: begin
        cmd.src = SRC_CRC_LO;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_CRC_HI;
        end
      end
      S_CRC_HI: begin
        cmd.src = SRC_CRC_HI;
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.clear_frame = 1'b1;
          state_nxt       = S_RX;
        end
      end
      default: state_nxt = S_RX;
    endcase
  end

  // Frame end always leads to the evaluation cycle
  a_end_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rx_take && in_tlast |=> state_r == S_CHECK)
    else $error("frame end did not reach check");

  // The evaluation state is never held
  a_check_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |=> state_r != S_CHECK)
    else $error("check state held");

  // No request taken while a response is in progress
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rx_take || cmd.upd_take) |-> state_r == S_RX)
    else $error("request taken while busy");

endmodule

/* design/mbrtu_dp.sv */
module mbrtu_dp
  import mbrtu_pkg::*;
  #(parameter int NUM_REGS  = MBRTU_NUM_REGS,
    parameter int MAX_FRAME = MBRTU_MAX_FRAME)
  (input  logic        clk,
   input  logic        rst_n,
   input  logic [31:0] in_tdata,
   input  logic        cfg_valid,
   input  logic [7:0]  cfg_data,
   output logic        cfg_ready,
   input  cmd_t        cmd,
   output sts_t        sts,
   output logic        out_tvalid,
   input  logic        out_tready,
   output logic [7:0]  out_tdata,
   output logic        out_tlast);

  localparam int AW  = NUM_REGS > 1 ? $clog2(NUM_REGS) : 1;
  localparam int CW  = $clog2(NUM_REGS + 1);
  localparam int RCW = $clog2(MAX_FRAME + 1);

  // Request fields
  logic [7:0]  rx_byte;
  logic [7:0]  idx_ext;
  logic [15:0] reg_value;
  assign rx_byte   = in_tdata[7:0];
  assign idx_ext   = {4'b0000, in_tdata[11:8]};
  assign reg_value = in_tdata[27:12];

  // Slave address register
  logic [7:0] slave_addr_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
    end else if (cfg_valid) begin
      slave_addr_r <= cfg_data;
    end
  end

  // Register bank: RAM plus per-entry valid bits (unwritten reads as zero)
  logic                upd_we;
  logic [AW-1:0]       waddr;
  logic [NUM_REGS-1:0] valid_r, valid_nxt;
  logic [AW-1:0]       rd_addr_r;
  logic [15:0]         rdata_r;
  logic                rd_vld_r;

  assign upd_we = cmd.upd_take && (idx_ext < 8'(NUM_REGS));
  assign waddr  = idx_ext[AW-1:0];

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      valid_nxt[i] = valid_r[i] | (upd_we && waddr == AW'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_vld_r <= valid_r[rd_addr_r];
  end

  mbrtu_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_bank (
    .clk     (clk),
    .we      (upd_we),
    .waddr   (waddr),
    .wdata   (reg_value),
    .re      (cmd.rd_issue),
    .raddr   (rd_addr_r),
    .rdata_r (rdata_r)
  );

  // Receive side: header capture, tail window, running CRC
  logic [RCW-1:0] rx_count_r;
  logic [15:0]    rx_crc_r;
  logic [7:0]     header_r [HDR_LEN];
  logic [7:0]     tail0_r, tail1_r;
  logic           rx_store;

  assign rx_store = cmd.rx_take && (rx_count_r < RCW'(MAX_FRAME));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_frame) begin
      rx_count_r <= '0;
      rx_crc_r   <= CRC_INIT;
    end else if (rx_store) begin
      rx_count_r <= rx_count_r + 1'b1;
      if (rx_count_r >= RCW'(2)) rx_crc_r <= crc_byte(rx_crc_r, tail0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rx_store) begin
      tail0_r <= tail1_r;
      tail1_r <= rx_byte;
      for (int i = 0; i < HDR_LEN; i++) begin
        if (rx_count_r == RCW'(i)) header_r[i] <= rx_byte;
      end
    end
  end

  // Frame evaluation
  logic [15:0] start_w, count_w;
  logic [16:0] end_w;
  logic        range_ok, is_fc04;

  assign start_w  = {header_r[2], header_r[3]};
  assign count_w  = {header_r[4], header_r[5]};
  assign end_w    = {1'b0, start_w} + {1'b0, count_w};
  assign range_ok = (count_w != 16'd0) && ({1'b0, count_w} <= 17'(NUM_REGS)) &&
                    ({1'b0, start_w} < 17'(NUM_REGS)) && (end_w <= 17'(NUM_REGS));
  assign is_fc04  = header_r[1] == FC_READ_INPUT;

  assign sts.frame_ok = (rx_count_r >= RCW'(MIN_FRAME)) && (header_r[0] == slave_addr_r) &&
                        ({tail1_r, tail0_r} == rx_crc_r);
  assign sts.resp_exc = !(is_fc04 && range_ok);

  // Response sequencing counters
  logic [1:0]    head_cnt_r;
  logic [CW-1:0] rem_r;

  assign sts.head_last = head_cnt_r == HEAD_INFO;
  assign sts.regs_last = rem_r == CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.start_resp) begin
      head_cnt_r <= HEAD_ADDR;
      rd_addr_r  <= header_r[3][AW-1:0];
      rem_r      <= header_r[5][CW-1:0];
    end else begin
      if (cmd.emit && cmd.src == SRC_HEAD) head_cnt_r <= head_cnt_r + 1'b1;
      if (cmd.reg_next) begin
        rd_addr_r <= rd_addr_r + 1'b1;
        rem_r     <= rem_r - 1'b1;
      end
    end
  end

  // Response byte select
  logic [7:0]  head_byte, tx_byte;
  logic [15:0] tx_crc_r;
  logic [15:0] reg_word;

  assign reg_word = rd_vld_r ? rdata_r : 16'h0000;

  always_comb begin
    case (head_cnt_r)
      HEAD_ADDR: head_byte = slave_addr_r;
      HEAD_FUNC: head_byte = sts.resp_exc ? (header_r[1] | EXC_FLAG) : FC_READ_INPUT;
      HEAD_INFO: head_byte = !sts.resp_exc ? {header_r[5][6:0], 1'b0} :
                             (is_fc04 ? EXC_ILLEGAL_ADDR : EXC_ILLEGAL_FUNC);
      default:   head_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd.src)
      SRC_HEAD:   tx_byte = head_byte;
      SRC_HI:     tx_byte = reg_word[15:8];
      SRC_LO:     tx_byte = reg_word[7:0];
      SRC_CRC_LO: tx_byte = tx_crc_r[7:0];
      SRC_CRC_HI: tx_byte = tx_crc_r[15:8];
      default:    tx_byte = 8'h00;
    endcase
  end

  // Response CRC over the body bytes
  always_ff @(posedge clk) begin
    if (cmd.start_resp) begin
      tx_crc_r <= CRC_INIT;
    end else if (cmd.emit && (cmd.src == SRC_HEAD || cmd.src == SRC_HI ||
                              cmd.src == SRC_LO)) begin
      tx_crc_r <= crc_byte(tx_crc_r, tx_byte);
    end
  end

  // Output register
  logic       out_vld_r;
  logic [7:0] out_data_r;
  logic       out_last_r;

  assign sts.out_free = !out_vld_r || out_tready;
  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= tx_byte;
      out_last_r <= cmd.src == SRC_CRC_HI;
    end
  end

  // A byte is loaded only when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("output register overwritten");

  // A bank read never runs past the requested range
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> rem_r != '0)
    else $error("register read past range");

  // Last flag marks the high CRC byte only
  a_last_crc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.src == SRC_CRC_HI |=> out_tvalid && out_tlast)
    else $error("response end not flagged");

endmodule
